[sv/u8r_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8r_pkg
// shared types, constants and the lead byte classifier of the utf-8
// sequence reassembler
// ----------------------------------------------------------------------------
package u8r_pkg;

  localparam int unsigned MAX_SEQ_BYTES_DEF = 6;
  localparam int unsigned CNT_W             = 3;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned QUEUE_PTR_W       = 1;

  localparam logic        KIND_DATA = 1'b0;
  localparam logic        KIND_TICK = 1'b1;

  localparam logic [2:0]  CLS_ASCII = 3'd0;
  localparam logic [2:0]  CLS_CONT  = 3'd1;

  // one queued request: held bytes to release, then an optional tail byte
  typedef struct packed {
    logic [CNT_W-1:0] held_cnt;
    logic             held_inv;
    logic             tail_vld;
    logic [7:0]       tail_byte;
    logic             tail_inv;
  } u8r_cmd_t;

  // 0 ascii, 1 continuation, 2..6 lead of that length (0xfe and 0xff also give 6)
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] cls;
    priority casez (b)
      8'b0???????: cls = CLS_ASCII;
      8'b10??????: cls = CLS_CONT;
      8'b110?????: cls = 3'd2;
      8'b1110????: cls = 3'd3;
      8'b11110???: cls = 3'd4;
      8'b111110??: cls = 3'd5;
      default:     cls = 3'd6;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

[sv/utf8_sequence_reassembler_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_sequence_reassembler_unit
// frames utf-8 characters from a byte stream and releases each byte marked
// valid or invalid
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// in_       in   in_valid/in_stall    in_kind, in_data_byte
// out_      out  out_valid/out_stall  out_byte, out_is_invalid, out_last
//
// the front takes one request per cycle while the two-entry queue has room
// the back sends one byte per cycle while out_stall does not hold the output
// register, so a request releasing n bytes sends them one after another
// results pass the queue, the back's request register and the output register
// rst_n is synchronous and clears pending state, queue, current request and output valid
// out_stall holds the output register; a full queue raises in_stall
// ----------------------------------------------------------------------------
module utf8_sequence_reassembler_unit #(
  parameter int unsigned MAX_SEQUENCE_BYTES = u8r_pkg::MAX_SEQ_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_is_invalid,
  output logic            out_last
);
  import u8r_pkg::*;

  localparam int unsigned HOLD = MAX_SEQUENCE_BYTES - 1;

  logic       push, q_full, q_valid, pop;
  u8r_cmd_t   push_cmd, q_cmd;
  logic [7:0] push_held [HOLD];
  logic [7:0] q_held    [HOLD];

  u8r_front #(
    .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES),
    .HOLD               (HOLD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_held    (push_held)
  );

  u8r_queue #(
    .HOLD (HOLD)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_held (push_held),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_held    (q_held),
    .pop       (pop)
  );

  u8r_back #(
    .HOLD (HOLD)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_held         (q_held),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_invalid (out_is_invalid),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

[sv/u8r_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8r_front
// accepts bytes and ticks, classifies them, keeps the partial character
// and issues release requests to the queue
// ----------------------------------------------------------------------------
module u8r_front #(
  parameter int unsigned MAX_SEQUENCE_BYTES = u8r_pkg::MAX_SEQ_BYTES_DEF,
  parameter int unsigned HOLD               = MAX_SEQUENCE_BYTES - 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_kind,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 q_full,
  output logic                      push,
  output u8r_pkg::u8r_cmd_t         push_cmd,
  output logic [7:0]                push_held [HOLD]
);
  import u8r_pkg::*;

  localparam int unsigned IDX_W = $clog2(HOLD);

  logic [7:0]       pend_r [HOLD];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       exp_r, exp_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             accept;
  logic [2:0]       cls;
  logic             complete;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cls      = lead_class(in_data_byte);
  assign complete = ({1'b0, cnt_r} + (CNT_W+1)'(1)) >= {{(CNT_W-2){1'b0}}, exp_r};

  always_comb begin
    cnt_nxt            = cnt_r;
    exp_nxt            = exp_r;
    wr_en              = 1'b0;
    wr_idx             = cnt_r[IDX_W-1:0];
    push               = 1'b0;
    push_cmd.held_cnt  = '0;
    push_cmd.held_inv  = 1'b1;
    push_cmd.tail_vld  = 1'b0;
    push_cmd.tail_byte = in_data_byte;
    push_cmd.tail_inv  = 1'b0;
    if (accept) begin
      if (in_kind == KIND_TICK) begin
        push_cmd.held_cnt = cnt_r;
        push              = (cnt_r != '0);
        cnt_nxt           = '0;
        exp_nxt           = '0;
      end else if (cnt_r != '0 && cls == CLS_CONT) begin
        if (complete) begin
          push_cmd.held_cnt = cnt_r;
          push_cmd.held_inv = 1'b0;
          push_cmd.tail_vld = 1'b1;
          push              = 1'b1;
          cnt_nxt           = '0;
          exp_nxt           = '0;
        end else if (cnt_r < CNT_W'(HOLD)) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end else begin
        push_cmd.held_cnt = cnt_r;
        cnt_nxt           = '0;
        exp_nxt           = '0;
        if (cls == CLS_ASCII) begin
          push_cmd.tail_vld = 1'b1;
        end else if (cls == CLS_CONT || cls > 3'(MAX_SEQUENCE_BYTES)) begin
          push_cmd.tail_vld = 1'b1;
          push_cmd.tail_inv = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = '0;
          cnt_nxt = CNT_W'(1);
          exp_nxt = cls;
        end
        push = push_cmd.tail_vld || (cnt_r != '0);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < HOLD; i++) begin
      push_held[i] = pend_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      exp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HOLD; i++) begin
      if (wr_en && wr_idx == IDX_W'(i)) begin
        pend_r[i] <= in_data_byte;
      end
    end
  end

endmodule
`default_nettype wire

[sv/u8r_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8r_queue
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module u8r_queue #(
  parameter int unsigned HOLD = u8r_pkg::MAX_SEQ_BYTES_DEF - 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire u8r_pkg::u8r_cmd_t    push_cmd,
  input  wire logic [7:0]           push_held [HOLD],
  output logic                      full,
  output logic                      q_valid,
  output u8r_pkg::u8r_cmd_t         q_cmd,
  output logic [7:0]                q_held [HOLD],
  input  wire logic                 pop
);
  import u8r_pkg::*;

  u8r_cmd_t               cmd_r  [QUEUE_DEPTH];
  logic [7:0]             held_r [QUEUE_DEPTH][HOLD];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   fill_r, fill_nxt;

  assign full    = (fill_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_cmd   = cmd_r[rd_ptr_r];

  always_comb begin
    for (int i = 0; i < HOLD; i++) begin
      q_held[i] = held_r[rd_ptr_r][i];
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r]  <= push_cmd;
      held_r[wr_ptr_r] <= push_held;
    end
  end

endmodule
`default_nettype wire

[sv/u8r_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8r_back
// takes release requests from the queue and sends their bytes out one per
// cycle while out_stall is low, through an output register
// ----------------------------------------------------------------------------
module u8r_back #(
  parameter int unsigned HOLD = u8r_pkg::MAX_SEQ_BYTES_DEF - 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire u8r_pkg::u8r_cmd_t    q_cmd,
  input  wire logic [7:0]           q_held [HOLD],
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_is_invalid,
  output logic                      out_last
);
  import u8r_pkg::*;

  localparam int unsigned IDX_W = $clog2(HOLD);

  logic             cur_vld_r, cur_vld_nxt;
  u8r_cmd_t         cur_cmd_r;
  logic [7:0]       cur_held_r [HOLD];
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_inv_r;
  logic             out_last_r;
  logic             emit, held_sel, is_final, done;
  logic [7:0]       sel_byte;
  logic             sel_inv;

  always_comb begin
    emit     = cur_vld_r && (!out_valid_r || !out_stall);
    held_sel = idx_r < cur_cmd_r.held_cnt;
    sel_byte = held_sel ? cur_held_r[idx_r[IDX_W-1:0]] : cur_cmd_r.tail_byte;
    sel_inv  = held_sel ? cur_cmd_r.held_inv : cur_cmd_r.tail_inv;
    is_final = cur_cmd_r.tail_vld ? !held_sel
                                  : ((idx_r + CNT_W'(1)) == cur_cmd_r.held_cnt);
    done     = emit && is_final;
    pop      = q_valid && (!cur_vld_r || done);

    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (pop) begin
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + CNT_W'(1);
    end

    out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_vld_r   <= cur_vld_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd_r  <= q_cmd;
      cur_held_r <= q_held;
    end
    if (emit) begin
      out_byte_r <= sel_byte;
      out_inv_r  <= sel_inv;
      out_last_r <= is_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_invalid = out_inv_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

[sv/u8r_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8r_checker
// port level checks of the utf-8 sequence reassembler
// ----------------------------------------------------------------------------
module u8r_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_kind,
  input wire logic [7:0] in_data_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_invalid,
  input wire logic       out_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_data_byte))
    else $error("stalled input request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_is_invalid) && $stable(out_last))
    else $error("stalled result changed");

  a_inv_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_invalid |-> out_byte[7])
    else $error("ascii byte marked invalid");

  a_mid_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_invalid && !out_last |-> out_byte[7])
    else $error("ascii byte inside a released character");

  a_end_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_invalid && out_last && out_byte[7] |-> !out_byte[6])
    else $error("valid character ends in a non-continuation byte");

endmodule

bind utf8_sequence_reassembler_unit u8r_checker u_u8r_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_kind        (in_kind),
  .in_data_byte   (in_data_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_is_invalid (out_is_invalid),
  .out_last       (out_last)
);
`default_nettype wire

[test/utf8_sequence_reassembler_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_sequence_reassembler_unit_test
// drives bytes and timeout ticks into the reassembler with random gaps and
// output back-pressure, predicts every released byte with its valid/invalid
// mark and last flag, and compares each result in order
// ----------------------------------------------------------------------------
module utf8_sequence_reassembler_unit_test;
  import u8r_pkg::*;

  localparam int unsigned SEQ_MAX     = MAX_SEQ_BYTES_DEF;
  localparam int unsigned HOLD_MAX    = SEQ_MAX - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] data;
    logic       invalid;
    logic       last;
  } release_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_invalid;
  logic       out_last;

  release_t    expected_release[$];
  release_t    head_release;
  logic [7:0]  held_bytes[HOLD_MAX];
  int unsigned held_count;
  int unsigned char_length;

  bit          idle_en;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned data_sent;
  int unsigned ticks_sent;
  int unsigned requests_seen;
  int unsigned results_checked;
  int unsigned invalid_checked;

  utf8_sequence_reassembler_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_invalid (out_is_invalid),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  // 0 ascii, 1 continuation, otherwise number of leading ones, at most 6
  function automatic int unsigned byte_class(input logic [7:0] b);
    int unsigned n;
    n = 0;
    if (!b[7]) return 0;
    while (n < 6 && b[7 - n]) n++;
    return n;
  endfunction

  function automatic void push_release(input logic [7:0] b, input logic inv);
    release_t r;
    r.data    = b;
    r.invalid = inv;
    r.last    = 1'b0;
    expected_release = {expected_release, r};
  endfunction

  function automatic void release_held(input logic inv);
    for (int i = 0; i < held_count && i < HOLD_MAX; i++) push_release(held_bytes[i], inv);
    held_count  = 0;
    char_length = 0;
  endfunction

  function automatic void predict_release(input logic kind, input logic [7:0] b);
    int unsigned cls;
    int unsigned start_size;
    start_size = expected_release.size();
    if (kind == KIND_TICK) begin
      release_held(1'b1);
    end else begin
      cls = byte_class(b);
      if (held_count > 0 && cls == CLS_CONT) begin
        if (held_count + 1 >= char_length) begin
          release_held(1'b0);
          push_release(b, 1'b0);
        end else if (held_count < HOLD_MAX) begin
          held_bytes[held_count] = b;
          held_count++;
        end
      end else begin
        if (held_count > 0) release_held(1'b1);
        if (cls == CLS_ASCII) begin
          push_release(b, 1'b0);
        end else if (cls == CLS_CONT || cls > SEQ_MAX) begin
          push_release(b, 1'b1);
        end else begin
          held_bytes[0] = b;
          held_count    = 1;
          char_length   = cls;
        end
      end
    end
    if (expected_release.size() > start_size) begin
      expected_release[expected_release.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request monitor and result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_release(in_kind, in_data_byte);
      requests_seen++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_is_invalid) invalid_checked++;
      if (expected_release.size() == 0) begin
        $error("unexpected result: out_byte %h out_is_invalid %b out_last %b",
               out_byte, out_is_invalid, out_last);
        fail_count++;
      end else begin
        head_release = expected_release.pop_front();
        if (out_byte !== head_release.data) begin
          $error("out_byte mismatch: expected %h, actual %h", head_release.data, out_byte);
          fail_count++;
        end
        if (out_is_invalid !== head_release.invalid) begin
          $error("out_is_invalid mismatch: expected %b, actual %b",
                 head_release.invalid, out_is_invalid);
          fail_count++;
        end
        if (out_last !== head_release.last) begin
          $error("out_last mismatch: expected %b, actual %b", head_release.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL utf8_sequence_reassembler_unit");
      $finish;
    end
  end

  // output back-pressure in short bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic kind, input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_DATA) data_sent++;
    else ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_request(KIND_DATA, b);
  endtask

  task automatic wait_all_released();
    in_valid <= 1'b0;
    while (expected_release.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_char();
    int unsigned pick;
    int unsigned len;
    int unsigned conts;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_data({1'b0, 7'($urandom)});
    end else if (pick < 38) begin
      send_data({2'b10, 6'($urandom)});
    end else if (pick < 46) begin
      send_request(KIND_TICK, 8'($urandom));
    end else begin
      len = $urandom_range(2, SEQ_MAX);
      if (len == 6) lead = {6'b111111, 2'($urandom)};
      else lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'h7F >> len));
      conts = len - 1;
      // truncated character, broken by whatever comes next
      if ($urandom_range(0, 4) == 0) conts = $urandom_range(0, len - 2);
      send_data(lead);
      repeat (conts) send_data({2'b10, 6'($urandom)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_ascii_and_stray();
    send_data(8'h00);
    send_data(8'h7F);
    send_data(8'h80);
    send_data(8'hBF);
  endtask

  task automatic test_complete_chars();
    send_data(8'hC0);
    send_data(8'hBF);
    send_data(8'hFF);
    repeat (4) send_data(8'h80);
    send_data(8'hBF);
  endtask

  task automatic test_early_break();
    send_data(8'hE0);
    send_data(8'h41);
    send_data(8'hE2);
    send_data(8'h82);
    send_data(8'hC3);
    send_data(8'hA9);
  endtask

  task automatic test_timeout_tick();
    send_data(8'hF0);
    send_data(8'h90);
    wait_all_released();
    send_request(KIND_TICK, 8'hFF);
    send_request(KIND_TICK, 8'h00);
  endtask

  task automatic test_random_stream();
    int unsigned goal;
    goal = data_sent + 380;
    while (data_sent < goal) begin
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (12) send_random_char();
    end
  endtask

  task automatic test_quiet_tail();
    int unsigned goal;
    idle_en = 1'b0;
    goal = data_sent + 40;
    while (data_sent < goal) send_random_char();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_DATA;
    in_data_byte = 8'h00;
    idle_en      = 1'b1;
    held_count   = 0;
    char_length  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ascii_and_stray();
    test_complete_chars();
    test_early_break();
    test_timeout_tick();
    test_random_stream();
    test_quiet_tail();

    in_valid <= 1'b0;
    while (expected_release.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests (%0d data bytes, %0d timeout ticks)",
             requests_seen, data_sent, ticks_sent);
    $display("checked %0d released bytes, %0d of them marked invalid",
             results_checked, invalid_checked);
    if (fail_count == 0) begin
      $display("PASS utf8_sequence_reassembler_unit");
    end else begin
      $display("FAIL utf8_sequence_reassembler_unit");
    end
    $finish;
  end

endmodule
